// ===== rtl/htmb_pkg.sv =====
// Shared types, constants and state encoding for the Huffman merge builder.
`default_nettype none
package htmb_pkg;

  localparam int unsigned MAX_LEAVES_DEF = 64;
  localparam int unsigned ID_W           = 7;
  localparam int unsigned FREQ_W         = 30;
  localparam int unsigned LEAF_W         = 24;
  localparam int unsigned MI_W           = 6;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [FREQ_W-1:0] freq;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   left_id;
    logic [ID_W-1:0]   right_id;
    logic [ID_W-1:0]   parent_id;
    logic [FREQ_W-1:0] parent_freq;
    logic              single_leaf;
    logic              is_root;
  } rec_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BH_RD,
    ST_BH_LD,
    ST_SD_RDL,
    ST_SD_RDR,
    ST_SD_CMP,
    ST_TM_RD0,
    ST_TM_RDL,
    ST_TM_LD,
    ST_SU_CHK,
    ST_SU_CMP,
    ST_EMIT
  } htmb_state_e;

endpackage
`default_nettype wire

// ===== rtl/htmb_ram.sv =====
// Heap store: single write port, single read port, registered read data.
`default_nettype none
module htmb_ram
  import htmb_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_LEAVES_DEF,
  parameter int unsigned AW    = $clog2(MAX_LEAVES_DEF)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/htmb_ctrl.sv =====
// Sequencer: leaf load, build-heap, extract-min and sift-up over the heap store.
`default_nettype none
module htmb_ctrl
  import htmb_pkg::*;
#(
  parameter int unsigned MAX_LEAVES = MAX_LEAVES_DEF,
  parameter int unsigned AW         = $clog2(MAX_LEAVES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [LEAF_W-1:0] leaf_freq_i,
  input  wire logic              last_leaf_i,
  output logic                   busy_o,
  output logic                   emit_o,
  output rec_t                   rec_o,
  output logic                   we_o,
  output logic [AW-1:0]          waddr_o,
  output entry_t                 wdata_o,
  output logic                   re_o,
  output logic [AW-1:0]          raddr_o,
  input  wire entry_t            rdata_i
);

  localparam int unsigned CW = AW + 1;
  localparam int unsigned XW = AW + 2;

  htmb_state_e      state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    n_q, n_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    bk_q, bk_d;
  logic [MI_W-1:0]  mi_q, mi_d;
  logic             take_q, take_d;
  logic             ret_take_q, ret_take_d;
  logic             r_ok_q, r_ok_d;
  entry_t           x_q, x_d, lval_q, lval_d, m1_q, m1_d, m2_q, m2_d;

  logic [XW-1:0]    l_idx, r_idx, cnt_x;
  logic             l_ok, r_ok, l_lt, r_lt, sd_stop, sift_done, is_last, store_ok;
  logic [FREQ_W-1:0] bf;
  entry_t           best_e, z;
  logic [AW-1:0]    best_pos, up_pos;
  logic [CW-1:0]    n_new;
  htmb_state_e      after_st;

  assign cnt_x    = XW'(cnt_q);
  assign l_idx    = XW'({pos_q, 1'b1});
  assign r_idx    = l_idx + XW'(1);
  assign l_ok     = l_idx < cnt_x;
  assign r_ok     = r_idx < cnt_x;
  assign l_lt     = lval_q.freq < x_q.freq;
  assign bf       = l_lt ? lval_q.freq : x_q.freq;
  assign r_lt     = r_ok_q && (rdata_i.freq < bf);
  assign sd_stop  = !l_lt && !r_lt;
  assign best_e   = r_lt ? rdata_i : lval_q;
  assign best_pos = r_lt ? r_idx[AW-1:0] : l_idx[AW-1:0];
  assign up_pos   = AW'((pos_q - AW'(1)) >> 1);
  assign z.id     = ID_W'(MAX_LEAVES) + ID_W'(mi_q);
  assign z.freq   = m1_q.freq + m2_q.freq;
  assign is_last  = ID_W'(mi_q) == (ID_W'(n_q) - ID_W'(2));
  assign store_ok = cnt_q < CW'(MAX_LEAVES);
  assign n_new    = store_ok ? cnt_q + CW'(1) : cnt_q;

  assign sift_done = (state_q == ST_SD_RDL && !l_ok) ||
                     (state_q == ST_SD_CMP && sd_stop) ||
                     (state_q == ST_TM_LD && cnt_q == '0);

  always_comb begin
    if (!ret_take_q) begin
      after_st = (bk_q == AW'(1)) ? ST_TM_RD0 : ST_BH_RD;
    end else begin
      after_st = take_q ? ST_SU_CHK : ST_TM_RD0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (start_i && last_leaf_i && n_new != CW'(1)) state_d = ST_BH_RD;
      end
      ST_BH_RD:  state_d = ST_BH_LD;
      ST_BH_LD:  state_d = ST_SD_RDL;
      ST_SD_RDL: state_d = l_ok ? ST_SD_RDR : after_st;
      ST_SD_RDR: state_d = ST_SD_CMP;
      ST_SD_CMP: state_d = sd_stop ? after_st : ST_SD_RDL;
      ST_TM_RD0: state_d = ST_TM_RDL;
      ST_TM_RDL: state_d = ST_TM_LD;
      ST_TM_LD:  state_d = (cnt_q == '0) ? after_st : ST_SD_RDL;
      ST_SU_CHK: state_d = (pos_q == '0) ? ST_EMIT : ST_SU_CMP;
      ST_SU_CMP: state_d = (x_q.freq < rdata_i.freq) ? ST_SU_CHK : ST_EMIT;
      ST_EMIT:   state_d = is_last ? ST_LOAD : ST_TM_RD0;
      default:   state_d = ST_LOAD;
    endcase
  end

  // datapath registers
  always_comb begin
    cnt_d      = cnt_q;
    n_d        = n_q;
    pos_d      = pos_q;
    bk_d       = bk_q;
    mi_d       = mi_q;
    take_d     = take_q;
    ret_take_d = ret_take_q;
    r_ok_d     = r_ok_q;
    x_d        = x_q;
    lval_d     = lval_q;
    m1_d       = m1_q;
    m2_d       = m2_q;
    case (state_q)
      ST_LOAD: begin
        if (start_i) begin
          cnt_d = n_new;
          if (last_leaf_i) begin
            if (n_new == CW'(1)) begin
              cnt_d = '0;
            end else begin
              n_d        = n_new;
              bk_d       = AW'(n_new >> 1);
              ret_take_d = 1'b0;
              take_d     = 1'b0;
              mi_d       = '0;
            end
          end
        end
      end
      ST_BH_RD:  pos_d = bk_q - AW'(1);
      ST_BH_LD:  x_d = rdata_i;
      ST_SD_RDR: begin
        lval_d = rdata_i;
        r_ok_d = r_ok;
      end
      ST_SD_CMP: begin
        if (!sd_stop) pos_d = best_pos;
      end
      ST_TM_RDL: begin
        if (take_q) m2_d = rdata_i;
        else m1_d = rdata_i;
        cnt_d = cnt_q - CW'(1);
      end
      ST_TM_LD: begin
        x_d        = rdata_i;
        pos_d      = '0;
        ret_take_d = 1'b1;
      end
      ST_SU_CMP: begin
        if (x_q.freq < rdata_i.freq) pos_d = up_pos;
      end
      ST_EMIT: begin
        mi_d = mi_q + MI_W'(1);
        if (is_last) begin
          cnt_d = '0;
          mi_d  = '0;
        end
      end
      default: ;
    endcase
    if (sift_done) begin
      if (!ret_take_q) begin
        bk_d = bk_q - AW'(1);
      end else if (!take_q) begin
        take_d = 1'b1;
      end else begin
        x_d    = z;
        pos_d  = cnt_q[AW-1:0];
        cnt_d  = cnt_q + CW'(1);
        take_d = 1'b0;
      end
    end
  end

  // outputs
  always_comb begin
    we_o    = 1'b0;
    waddr_o = pos_q;
    wdata_o = x_q;
    re_o    = 1'b0;
    raddr_o = '0;
    emit_o  = 1'b0;
    rec_o   = '{left_id: m1_q.id, right_id: m2_q.id, parent_id: z.id,
                parent_freq: z.freq, single_leaf: 1'b0, is_root: is_last};
    case (state_q)
      ST_LOAD: begin
        we_o         = start_i && store_ok;
        waddr_o      = cnt_q[AW-1:0];
        wdata_o.id   = ID_W'(cnt_q);
        wdata_o.freq = FREQ_W'(leaf_freq_i);
        if (start_i && last_leaf_i && n_new == CW'(1)) begin
          emit_o = 1'b1;
          rec_o  = '{left_id: '0, right_id: '0, parent_id: '0,
                     parent_freq: FREQ_W'(leaf_freq_i), single_leaf: 1'b1, is_root: 1'b1};
        end
      end
      ST_BH_RD: begin
        re_o    = 1'b1;
        raddr_o = bk_q - AW'(1);
      end
      ST_SD_RDL: begin
        if (l_ok) begin
          re_o    = 1'b1;
          raddr_o = l_idx[AW-1:0];
        end else begin
          we_o = 1'b1;
        end
      end
      ST_SD_RDR: begin
        re_o    = r_ok;
        raddr_o = r_idx[AW-1:0];
      end
      ST_SD_CMP: begin
        we_o    = 1'b1;
        wdata_o = sd_stop ? x_q : best_e;
      end
      ST_TM_RD0: re_o = 1'b1;
      ST_TM_RDL: begin
        re_o    = 1'b1;
        raddr_o = AW'(cnt_q - CW'(1));
      end
      ST_SU_CHK: begin
        if (pos_q == '0) begin
          we_o = 1'b1;
        end else begin
          re_o    = 1'b1;
          raddr_o = up_pos;
        end
      end
      ST_SU_CMP: begin
        we_o    = 1'b1;
        wdata_o = (x_q.freq < rdata_i.freq) ? rdata_i : x_q;
      end
      ST_EMIT: emit_o = 1'b1;
      default: ;
    endcase
  end

  assign busy_o = state_q != ST_LOAD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      mi_q       <= '0;
      take_q     <= 1'b0;
      ret_take_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      mi_q       <= mi_d;
      take_q     <= take_d;
      ret_take_q <= ret_take_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    pos_q  <= pos_d;
    bk_q   <= bk_d;
    r_ok_q <= r_ok_d;
    x_q    <= x_d;
    lval_q <= lval_d;
    m1_q   <= m1_d;
    m2_q   <= m2_d;
  end

endmodule
`default_nettype wire

// ===== rtl/huffman_tree_merge_builder.sv =====
// Leaves load one per cycle (busy_o low); the last leaf starts a burst with busy_o high.
// Burst: build-heap then n-1 merges through one registered-read store; a merge is
// two extract-mins, a sift-up and the emit.
// Each merge record appears on out_valid_o for one cycle, in the cycle after it forms.
// A one-leaf tree gives its record in the cycle after the leaf, with no burst.
// Asynchronous active-low reset empties the store and returns to leaf loading.
`default_nettype none
module huffman_tree_merge_builder
  import htmb_pkg::*;
#(
  parameter int unsigned MAX_LEAVES = MAX_LEAVES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [LEAF_W-1:0] leaf_freq_i,
  input  wire logic              last_leaf_i,
  output logic                   out_valid_o,
  output logic [ID_W-1:0]        left_id_o,
  output logic [ID_W-1:0]        right_id_o,
  output logic [ID_W-1:0]        parent_id_o,
  output logic [FREQ_W-1:0]      parent_freq_o,
  output logic                   single_leaf_o,
  output logic                   is_root_o
);

  localparam int unsigned AW = $clog2(MAX_LEAVES);

  logic          we, re, emit;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  rec_t          rec, rec_q;
  logic          valid_q;

  htmb_ram #(.DEPTH(MAX_LEAVES), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  htmb_ctrl #(.MAX_LEAVES(MAX_LEAVES), .AW(AW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .leaf_freq_i (leaf_freq_i),
    .last_leaf_i (last_leaf_i),
    .busy_o      (busy_o),
    .emit_o      (emit),
    .rec_o       (rec),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rec_q <= rec;
    end
  end

  assign out_valid_o   = valid_q;
  assign left_id_o     = rec_q.left_id;
  assign right_id_o    = rec_q.right_id;
  assign parent_id_o   = rec_q.parent_id;
  assign parent_freq_o = rec_q.parent_freq;
  assign single_leaf_o = rec_q.single_leaf;
  assign is_root_o     = rec_q.is_root;

`ifndef NO_ASSERTIONS
  a_single_is_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && single_leaf_o |-> is_root_o && left_id_o == '0 && right_id_o == '0)
    else $error("single-leaf record malformed");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i) && $past(last_leaf_i))
    else $error("burst started without a last leaf");

  a_merge_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !single_leaf_o |-> $past(busy_o))
    else $error("merge record outside a burst");

  a_root_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_root_o && !single_leaf_o |-> !busy_o)
    else $error("root record while burst continues");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_huffman_tree_merge_builder.sv =====
// Self-checking testbench for the Huffman merge builder: directed table, a full-capacity tree, then random trees.
`default_nettype none
module tb_huffman_tree_merge_builder;
  import htmb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = MAX_LEAVES_DEF;
  localparam int unsigned CYCLE_LIMIT = 900000;

  typedef struct {
    logic [LEAF_W-1:0] freq;
    logic              last;
    logic              typed;
    rec_t              rec;
  } leaf_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [LEAF_W-1:0] leaf_freq_i = '0;
  logic              last_leaf_i = 1'b0;
  logic              busy_o, out_valid_o, single_leaf_o, is_root_o;
  logic [ID_W-1:0]   left_id_o, right_id_o, parent_id_o;
  logic [FREQ_W-1:0] parent_freq_o;

  entry_t  tree_heap[CAP];
  int      tree_count = 0;
  rec_t    merge_q[$];
  int      fail_count = 0;
  int      cycles = 0;

  huffman_tree_merge_builder dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("** huffman_tree_merge_builder: FAILED **");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    rec_t want;
    if (rst_ni && out_valid_o) begin
      if (merge_q.size() == 0) begin
        report($sformatf("unexpected merge record parent %0d", parent_id_o));
      end else begin
        want = merge_q.pop_front();
        if (left_id_o !== want.left_id)
          report($sformatf("left_id %0d want %0d", left_id_o, want.left_id));
        if (right_id_o !== want.right_id)
          report($sformatf("right_id %0d want %0d", right_id_o, want.right_id));
        if (parent_id_o !== want.parent_id)
          report($sformatf("parent_id %0d want %0d", parent_id_o, want.parent_id));
        if (parent_freq_o !== want.parent_freq)
          report($sformatf("parent_freq %0d want %0d", parent_freq_o, want.parent_freq));
        if (single_leaf_o !== want.single_leaf)
          report($sformatf("single_leaf %0b want %0b", single_leaf_o, want.single_leaf));
        if (is_root_o !== want.is_root)
          report($sformatf("is_root %0b want %0b", is_root_o, want.is_root));
      end
    end
  end

  function automatic void swap_nodes(int a, int b);
    entry_t t;
    t = tree_heap[a];
    tree_heap[a] = tree_heap[b];
    tree_heap[b] = t;
  endfunction

  function automatic void sink_node(int pos);
    int best, l, r;
    forever begin
      best = pos;
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      if (l < tree_count && tree_heap[l].freq < tree_heap[best].freq) best = l;
      if (r < tree_count && tree_heap[r].freq < tree_heap[best].freq) best = r;
      if (best == pos) return;
      swap_nodes(pos, best);
      pos = best;
    end
  endfunction

  function automatic void float_node(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(tree_heap[pos].freq < tree_heap[up].freq)) return;
      swap_nodes(pos, up);
      pos = up;
    end
  endfunction

  function automatic entry_t pop_lightest();
    entry_t m;
    m = tree_heap[0];
    tree_heap[0] = tree_heap[tree_count - 1];
    tree_count--;
    if (tree_count > 0) sink_node(0);
    return m;
  endfunction

  // Adds the leaf and, on the last mark, queues every merge record of the tree.
  function automatic void predict_merges(logic [LEAF_W-1:0] freq, logic last);
    int n;
    entry_t x, y, z;
    rec_t r;
    if (tree_count < CAP) begin
      tree_heap[tree_count].id = ID_W'(tree_count);
      tree_heap[tree_count].freq = FREQ_W'(freq);
      tree_count++;
    end
    if (!last) return;
    n = tree_count;
    if (n == 1) begin
      r = '0;
      r.parent_id = tree_heap[0].id;
      r.parent_freq = tree_heap[0].freq;
      r.single_leaf = 1'b1;
      r.is_root = 1'b1;
      merge_q.push_back(r);
      tree_count = 0;
      return;
    end
    for (int k = n / 2; k > 0; k--) sink_node(k - 1);
    for (int k = 1; k < n; k++) begin
      x = pop_lightest();
      y = pop_lightest();
      z.id = ID_W'(CAP + k - 1);
      z.freq = x.freq + y.freq;
      r.left_id = x.id;
      r.right_id = y.id;
      r.parent_id = z.id;
      r.parent_freq = z.freq;
      r.single_leaf = 1'b0;
      r.is_root = (k == n - 1);
      merge_q.push_back(r);
      tree_heap[tree_count] = z;
      tree_count++;
      float_node(tree_count - 1);
    end
    tree_count = 0;
  endfunction

  task automatic send_leaf(input logic [LEAF_W-1:0] freq, input logic last);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    leaf_freq_i <= freq;
    last_leaf_i <= last;
    do @(posedge clk_i); while (busy_o);
    predict_merges(freq, last);
  endtask

  leaf_row_t rows[$];

  function automatic rec_t single_rec(int unsigned f);
    rec_t r;
    r = '0;
    r.parent_freq = FREQ_W'(f);
    r.single_leaf = 1'b1;
    r.is_root = 1'b1;
    return r;
  endfunction

  function automatic void add_row(int unsigned f, bit last, bit typed, rec_t r);
    leaf_row_t row;
    row.freq = LEAF_W'(f);
    row.last = last;
    row.typed = typed;
    row.rec = r;
    rows.push_back(row);
  endfunction

  initial begin
    int sent, tree_len, mode;
    logic [LEAF_W-1:0] f;
    rec_t none;
    none = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single leaf trees at the extremes, with typed records
    add_row(0, 1, 1, single_rec(0));
    add_row(24'hFFFFFF, 1, 1, single_rec(24'hFFFFFF));
    // two max leaves: sum carries past 24 bits
    add_row(24'hFFFFFF, 0, 0, none);
    add_row(24'hFFFFFF, 1, 0, none);
    // equal and descending frequencies
    add_row(5, 0, 0, none);
    add_row(5, 0, 0, none);
    add_row(5, 1, 0, none);
    add_row(40, 0, 0, none);
    add_row(30, 0, 0, none);
    add_row(20, 0, 0, none);
    add_row(10, 1, 0, none);
    add_row(24'hAAAAAA, 0, 0, none);
    add_row(24'h555555, 0, 0, none);
    add_row(0, 1, 0, none);
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        send_leaf(rows[i].freq, rows[i].last);
        void'(merge_q.pop_back());
        merge_q.push_back(rows[i].rec);
      end else begin
        send_leaf(rows[i].freq, rows[i].last);
      end
    end

    // full capacity plus dropped leaves, large values
    for (int i = 0; i < CAP + 3; i++)
      send_leaf(LEAF_W'($urandom()), i == CAP + 2);

    sent = 0;
    while (sent < 180) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) tree_len = 1;
      else if (mode == 1) tree_len = $urandom_range(30, CAP);
      else tree_len = $urandom_range(2, 12);
      for (int i = 0; i < tree_len; i++) begin
        case ($urandom_range(0, 3))
          0: f = LEAF_W'($urandom_range(0, 7));
          1: f = LEAF_W'($urandom());
          2: f = 24'hFFFFFF - LEAF_W'($urandom_range(0, 3));
          default: f = LEAF_W'($urandom_range(0, 1000));
        endcase
        send_leaf(f, i == tree_len - 1);
        sent++;
      end
    end
    start_i <= 1'b0;
    last_leaf_i <= 1'b0;

    while (merge_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && merge_q.size() == 0) begin
      $display("** huffman_tree_merge_builder: PASSED **");
    end else begin
      $display("** huffman_tree_merge_builder: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/htmb_pkg.sv
rtl/htmb_ram.sv
rtl/htmb_ctrl.sv
rtl/huffman_tree_merge_builder.sv
tb/tb_huffman_tree_merge_builder.sv
